>>> hdl/ubxfb_pkg.sv
// Package for the UBX frame builder: sync constants, register indexes,
// result burst sizing and the Fletcher-8 update function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ubxfb_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam int BURST_MAX = 8;
    localparam int CNT_W     = $clog2(BURST_MAX + 1);

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MSG_CLASS      = 2'd0,
        CFG_MSG_ID         = 2'd1,
        CFG_PAYLOAD_LENGTH = 2'd2,
        CFG_UNUSED         = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        MODE_START   = 1'b0,
        MODE_PAYLOAD = 1'b1
    } t_mode;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
    } t_sum;

    localparam logic [7:0]        RST_MSG_CLASS = 8'd10;
    localparam logic [7:0]        RST_MSG_ID    = 8'd9;
    localparam logic [CNT_W-1:0]  CNT_HEADER    = CNT_W'(6);
    localparam logic [CNT_W-1:0]  CNT_FULL      = CNT_W'(8);
    localparam logic [CNT_W-1:0]  CNT_TAIL      = CNT_W'(3);
    localparam logic [CNT_W-1:0]  CNT_ONE       = CNT_W'(1);

    function automatic t_sum fletcher_add(input t_sum s, input logic [7:0] x);
        t_sum r;
        r.a = s.a + x;
        r.b = s.b + r.a;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/ubx_frame_builder_core.sv
// Top level of the UBX frame builder: frame state, checksum and result burst.
// Depends on ubxfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage: items enter on i_in_valid/o_in_ready with i_mode and i_data_byte.
// A start item (mode 0) yields the sync bytes, class, id and the little-endian
// length, followed by ck_a and ck_b when the length is zero. A payload item
// (mode 1) yields its byte, and ck_a and ck_b after the last payload byte.
// A payload item with no open frame yields one result with o_misuse set.
// Results leave one byte per cycle on o_out_valid/i_out_ready while the
// receiver is ready; o_frame_end marks ck_b. An accepted item is turned into
// its whole burst at once, held in an output shift register, so the first
// result appears in the cycle after acceptance. The output port sets the
// rate: an item is taken in the cycle its predecessor's last result is taken,
// so with a ready receiver payload items run at one item per cycle; a start
// item yields six or eight results. o_in_ready depends on i_out_ready.
// Configuration writes on i_cfg_we take effect at the next start item.
// Synchronous reset clears the frame state and restores the register
// defaults. While the receiver stalls, the held result stays unchanged.
module ubx_frame_builder_core (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [ubxfb_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire  [ubxfb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire                                   i_mode,
    input  wire  [7:0]                            i_data_byte,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic [7:0]                            o_tx_byte,
    output logic                                  o_frame_end,
    output logic                                  o_misuse
);
    import ubxfb_pkg::*;

    logic [7:0]       r_msg_class;
    logic [7:0]       r_msg_id;
    logic [15:0]      r_payload_length;

    logic             r_in_frame, n_in_frame;
    logic [15:0]      r_bytes_left, n_bytes_left;
    t_sum             r_sum, n_sum;

    logic [7:0]       r_bytes [BURST_MAX];
    logic [7:0]       n_bytes [BURST_MAX];
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_end, n_end;
    logic             r_mis, n_mis;

    logic             w_last;
    logic             w_take;
    logic             w_load;
    t_sum             w_s0, w_s1, w_s2, w_s3, w_sp;
    logic [15:0]      w_left_dec;

    assign o_out_valid = (r_cnt != '0);
    assign w_last      = (r_cnt == CNT_ONE);
    assign w_take      = o_out_valid && i_out_ready;
    assign o_in_ready  = !o_out_valid || (w_take && w_last);
    assign w_load      = i_in_valid && o_in_ready;

    assign o_tx_byte   = r_bytes[0];
    assign o_frame_end = r_end && w_last;
    assign o_misuse    = r_mis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_class      <= RST_MSG_CLASS;
            r_msg_id         <= RST_MSG_ID;
            r_payload_length <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_MSG_CLASS:      r_msg_class      <= i_cfg_data[7:0];
                CFG_MSG_ID:         r_msg_id         <= i_cfg_data[7:0];
                CFG_PAYLOAD_LENGTH: r_payload_length <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_s0       = fletcher_add('0, r_msg_class);
        w_s1       = fletcher_add(w_s0, r_msg_id);
        w_s2       = fletcher_add(w_s1, r_payload_length[7:0]);
        w_s3       = fletcher_add(w_s2, r_payload_length[15:8]);
        w_sp       = fletcher_add(r_sum, i_data_byte);
        w_left_dec = r_bytes_left - 16'd1;
    end

    always_comb begin
        n_in_frame   = r_in_frame;
        n_bytes_left = r_bytes_left;
        n_sum        = r_sum;
        n_bytes      = r_bytes;
        n_cnt        = r_cnt;
        n_end        = r_end;
        n_mis        = r_mis;
        if (w_take) begin
            for (int k = 0; k < BURST_MAX - 1; k++) begin
                n_bytes[k] = r_bytes[k + 1];
            end
            n_cnt = r_cnt - CNT_ONE;
        end
        if (w_load) begin
            n_end = 1'b0;
            n_mis = 1'b0;
            if (t_mode'(i_mode) == MODE_START) begin
                n_bytes[0]   = SYNC_FIRST;
                n_bytes[1]   = SYNC_SECOND;
                n_bytes[2]   = r_msg_class;
                n_bytes[3]   = r_msg_id;
                n_bytes[4]   = r_payload_length[7:0];
                n_bytes[5]   = r_payload_length[15:8];
                n_bytes[6]   = w_s3.a;
                n_bytes[7]   = w_s3.b;
                n_sum        = w_s3;
                n_bytes_left = r_payload_length;
                if (r_payload_length == '0) begin
                    n_cnt      = CNT_FULL;
                    n_end      = 1'b1;
                    n_in_frame = 1'b0;
                end else begin
                    n_cnt      = CNT_HEADER;
                    n_in_frame = 1'b1;
                end
            end else if (!r_in_frame) begin
                n_bytes[0] = '0;
                n_cnt      = CNT_ONE;
                n_mis      = 1'b1;
            end else begin
                n_bytes[0]   = i_data_byte;
                n_bytes[1]   = w_sp.a;
                n_bytes[2]   = w_sp.b;
                n_sum        = w_sp;
                n_bytes_left = w_left_dec;
                if (w_left_dec == '0) begin
                    n_cnt      = CNT_TAIL;
                    n_end      = 1'b1;
                    n_in_frame = 1'b0;
                end else begin
                    n_cnt = CNT_ONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_bytes_left <= '0;
            r_sum        <= '0;
            r_cnt        <= '0;
            r_end        <= 1'b0;
            r_mis        <= 1'b0;
        end else begin
            r_in_frame   <= n_in_frame;
            r_bytes_left <= n_bytes_left;
            r_sum        <= n_sum;
            r_cnt        <= n_cnt;
            r_end        <= n_end;
            r_mis        <= n_mis;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

    a_misuse_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_misuse) |-> (w_last && !r_end))
        else $error("misuse result is not a lone result");

    a_end_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_end |-> (o_out_valid && !o_misuse))
        else $error("frame end without a valid frame byte");

    a_start_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (t_mode'(i_mode) == MODE_START)) |=>
            (o_out_valid && (o_tx_byte == SYNC_FIRST) && !o_misuse))
        else $error("start item did not begin with the first sync byte");

    a_open_frame_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> (r_bytes_left != '0))
        else $error("open frame with no payload bytes due");

endmodule

`default_nettype wire
